// ----- src/csvfs_pkg.sv -----
// Shared types and constants for the CSV field splitter.
// No dependencies; the parser, the top level and the testbench import this package.
`default_nettype none

package csvfs_pkg;

  localparam int MAX_FIELDS = 64;
  localparam int FIELD_W    = $clog2(MAX_FIELDS);
  localparam int COUNT_W    = FIELD_W + 1;

  localparam logic [7:0] BACKSLASH_BYTE = 8'h5C;
  localparam logic [7:0] DQUOTE_BYTE    = 8'h22;

  // configuration register indexes
  localparam int CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] CFG_QUOTE      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SEPARATOR  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_RECORD     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_NUM_FIELDS = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_LOAD_MASK  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_SKIP_HDR   = 3'd5;
  localparam int CFG_DATA_W = 64;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_BAD_TERM   = 2'd1,
    STATUS_INCOMPLETE = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0]            quote_char;
    logic [7:0]            separator_char;
    logic [7:0]            record_char;
    logic [6:0]            num_fields;
    logic [MAX_FIELDS-1:0] load_mask;
    logic                  skip_header;
  } cfg_t;

  typedef struct packed {
    logic               inside_field;
    logic               quoted_field;
    logic               escape_active;
    logic               await_terminator;
    logic [FIELD_W-1:0] current_field;
    logic [31:0]        row_count;
    status_t            error_code;
  } parse_state_t;

  typedef struct packed {
    logic               content_valid;
    logic [7:0]         content_byte;
    logic [FIELD_W-1:0] field_number;
    logic               field_done;
    logic               field_wanted;
    logic               row_done;
    logic               blank_previous;
    status_t            status;
    logic [31:0]        rows_seen;
    logic               end_report;
  } result_t;

endpackage

`default_nettype wire

// ----- src/csvfs_text_if.sv -----
// Input channel of the CSV field splitter: one byte or end marker per item.
// Depends on nothing.
`default_nettype none

interface csvfs_text_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] in_byte;

  modport source (output valid, kind, in_byte, input ready);
  modport sink   (input valid, kind, in_byte, output ready);
endinterface

`default_nettype wire

// ----- src/csvfs_token_if.sv -----
// Result channel of the CSV field splitter: one classified byte per item.
// Depends on nothing.
`default_nettype none

interface csvfs_token_if;
  logic        valid;
  logic        ready;
  logic        content_valid;
  logic [7:0]  content_byte;
  logic [5:0]  field_number;
  logic        field_done;
  logic        field_wanted;
  logic        row_done;
  logic        blank_previous;
  logic [1:0]  status;
  logic [31:0] rows_seen;
  logic        end_report;

  modport source (output valid, content_valid, content_byte, field_number, field_done,
                  field_wanted, row_done, blank_previous, status, rows_seen,
                  end_report, input ready);
  modport sink   (input valid, content_valid, content_byte, field_number, field_done,
                  field_wanted, row_done, blank_previous, status, rows_seen,
                  end_report, output ready);
endinterface

`default_nettype wire

// ----- src/csvfs_parser.sv -----
// Tokenizer state and per-byte classification for the CSV field splitter.
// Depends on csvfs_pkg.
`default_nettype none

module csvfs_parser
  import csvfs_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         step,
  input  logic         kind,
  input  logic [7:0]   in_byte,
  input  cfg_t         cfg,
  output result_t      result,
  output parse_state_t state
);

  parse_state_t       state_next;
  logic [COUNT_W-1:0] total;
  logic [FIELD_W-1:0] cf;
  logic               last;
  logic               header;
  logic               wanted;
  logic [7:0]         term;
  logic               ended;
  logic               esc;
  logic               escaped;

  // clamp field count to 1..MAX_FIELDS
  always_comb begin
    if (cfg.num_fields == '0) begin
      total = COUNT_W'(1);
    end else if (cfg.num_fields > 7'(MAX_FIELDS)) begin
      total = COUNT_W'(MAX_FIELDS);
    end else begin
      total = COUNT_W'(cfg.num_fields);
    end
  end

  assign cf     = state.current_field;
  assign last   = ({1'b0, cf} + COUNT_W'(1)) >= total;
  assign header = cfg.skip_header && (state.row_count == '0);
  assign wanted = cfg.load_mask[cf] && !header;
  assign term   = last ? cfg.record_char : cfg.separator_char;

  always_comb begin
    state_next          = state;
    result              = '0;
    result.field_number = cf;
    result.status       = state.error_code;
    result.rows_seen    = state.row_count;
    ended               = 1'b0;
    esc                 = state.escape_active;
    escaped             = 1'b0;

    if (kind) begin
      if (state.error_code == STATUS_OK &&
          (state.inside_field || state.await_terminator || cf != '0)) begin
        state_next.error_code = STATUS_INCOMPLETE;
      end
      result.status     = state_next.error_code;
      result.rows_seen  = state.row_count -
                          32'(cfg.skip_header && (state.row_count != '0));
      result.end_report = 1'b1;
    end else if (state.error_code == STATUS_OK) begin
      if (state.await_terminator) begin
        state_next.await_terminator = 1'b0;
        if (in_byte == term) begin
          ended = 1'b1;
        end else begin
          state_next.error_code = STATUS_BAD_TERM;
        end
      end else begin
        // stray escape: blank the backslash and leave escape mode
        if (esc && in_byte != BACKSLASH_BYTE && in_byte != DQUOTE_BYTE) begin
          result.blank_previous = 1'b1;
          esc                   = 1'b0;
        end
        if (in_byte == BACKSLASH_BYTE) begin
          esc = !esc;
        end
        if (in_byte == DQUOTE_BYTE && esc) begin
          escaped = 1'b1;
          esc     = 1'b0;
        end
        state_next.escape_active = esc;

        if (!state.inside_field) begin
          if (in_byte == cfg.quote_char) begin
            state_next.inside_field = 1'b1;
            state_next.quoted_field = 1'b1;
          end else if (in_byte == term) begin
            ended = 1'b1;
          end else begin
            state_next.inside_field = 1'b1;
            state_next.quoted_field = 1'b0;
            result.content_valid    = 1'b1;
          end
        end else if (state.quoted_field) begin
          if (in_byte == cfg.quote_char && !escaped) begin
            state_next.inside_field     = 1'b0;
            state_next.quoted_field     = 1'b0;
            state_next.await_terminator = 1'b1;
          end else begin
            result.content_valid = 1'b1;
          end
        end else begin
          if (in_byte == term) begin
            state_next.inside_field = 1'b0;
            ended                   = 1'b1;
          end else begin
            result.content_valid = 1'b1;
          end
        end
      end

      if (ended) begin
        result.field_done = 1'b1;
        if (last) begin
          result.row_done = 1'b1;
          if (state.row_count != '1) begin
            state_next.row_count = state.row_count + 32'd1;
          end
          state_next.current_field = '0;
        end else begin
          state_next.current_field = cf + FIELD_W'(1);
        end
      end

      // a bad terminator reports only field number, status and row count
      if (state_next.error_code == STATUS_OK) begin
        result.content_byte = in_byte;
        result.field_wanted = wanted;
      end
      result.status    = state_next.error_code;
      result.rows_seen = state_next.row_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (step) begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ----- src/csv_field_splitter_top.sv -----
// Top level of the CSV field splitter: configuration registers, input stage,
// result register. Depends on csvfs_pkg, csvfs_text_if, csvfs_token_if and csvfs_parser.
`default_nettype none

// The splitter takes one CSV byte (or an end-of-input marker) per item and
// returns exactly one result item for it: whether the byte is field content,
// which field of the row it belongs to, whether it closed a field or a row,
// a request to blank the previous byte after a stray backslash, the sticky
// status and the row count. It accepts one item every clock cycle while the
// result side does not stall. An accepted item is held in the input register,
// then the classification logic, whose only loop-carried state is a handful of
// flags, the sticky status, the field index and the row counter, updates that state
// and loads the result register. The result register and the input register
// decouple the two channels, so a stall on the result side holds both stages
// and a free result slot lets a new item in on the same edge. Configuration
// registers are written through cfg_we/cfg_index/cfg_data and must only be
// changed while no item is in flight; an out-of-range index is ignored.
module csv_field_splitter_top
  import csvfs_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  csvfs_text_if.sink             text,
  csvfs_token_if.source          tokens,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t         cfg;
  logic         s1_valid;
  logic         s1_kind;
  logic [7:0]   s1_byte;
  logic         out_valid;
  result_t      out_res;
  result_t      result;
  parse_state_t state;
  logic         advance;
  logic         step;
  logic         accept;

  // Configuration registers: write-only, reset to the documented defaults.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.quote_char     <= 8'd34;
      cfg.separator_char <= 8'd44;
      cfg.record_char    <= 8'd10;
      cfg.num_fields     <= 7'd1;
      cfg.load_mask      <= '1;
      cfg.skip_header    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_QUOTE:      cfg.quote_char     <= cfg_data[7:0];
        CFG_SEPARATOR:  cfg.separator_char <= cfg_data[7:0];
        CFG_RECORD:     cfg.record_char    <= cfg_data[7:0];
        CFG_NUM_FIELDS: cfg.num_fields     <= cfg_data[6:0];
        CFG_LOAD_MASK:  cfg.load_mask      <= cfg_data[MAX_FIELDS-1:0];
        CFG_SKIP_HDR:   cfg.skip_header    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Advance the input stage whenever the result slot is free or being taken.
  assign advance    = !out_valid || tokens.ready;
  assign step       = s1_valid && advance;
  assign text.ready = !s1_valid || advance;
  assign accept     = text.valid && text.ready;

  // Input stage: hold the item until the parser consumes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (step) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_kind <= text.kind;
      s1_byte <= text.in_byte;
    end
  end

  csvfs_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .kind    (s1_kind),
    .in_byte (s1_byte),
    .cfg     (cfg),
    .result  (result),
    .state   (state)
  );

  // Result register: load on step, drop once the sink takes the item.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (tokens.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res <= result;
    end
  end

  assign tokens.valid          = out_valid;
  assign tokens.content_valid  = out_res.content_valid;
  assign tokens.content_byte   = out_res.content_byte;
  assign tokens.field_number   = out_res.field_number;
  assign tokens.field_done     = out_res.field_done;
  assign tokens.field_wanted   = out_res.field_wanted;
  assign tokens.row_done       = out_res.row_done;
  assign tokens.blank_previous = out_res.blank_previous;
  assign tokens.status         = out_res.status;
  assign tokens.rows_seen      = out_res.rows_seen;
  assign tokens.end_report     = out_res.end_report;

  // Once an error is recorded it never changes.
  a_error_sticky : assert property (@(posedge clk) disable iff (rst)
    (state.error_code != STATUS_OK) |=> (state.error_code == $past(state.error_code)))
    else $error("error code changed after being set");

  // A closing quote leaves the field before a terminator is awaited.
  a_await_outside : assert property (@(posedge clk) disable iff (rst)
    state.await_terminator |-> (!state.inside_field && !state.quoted_field))
    else $error("terminator awaited while still inside a field");

  // A completed row always closes its last field on the same item.
  a_row_needs_field : assert property (@(posedge clk) disable iff (rst)
    (tokens.valid && tokens.row_done) |-> (tokens.field_done && !tokens.end_report))
    else $error("row completed without a field completing");

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for csv_field_splitter_top: bursty byte stream in, stalled results out.
// Depends on csvfs_pkg, csvfs_text_if, csvfs_token_if and the block's RTL only.

module tb;
  import csvfs_pkg::*;

  // Scoreboard: its own copy of the parser state and registers, one expected
  // result per accepted item, field-by-field comparison on delivery.
  class token_scoreboard;
    cfg_t               regs;
    logic               in_field;
    logic               quoted;
    logic               escaping;
    logic               await_term;
    logic [FIELD_W-1:0] cur_field;
    logic [31:0]        row_count;
    status_t            err;
    result_t            tokens_due[$];
    int                 mismatches;
    int                 checked;

    function new();
      regs.quote_char     = 8'h22;
      regs.separator_char = 8'h2C;
      regs.record_char    = 8'h0A;
      regs.num_fields     = 7'd1;
      regs.load_mask      = '1;
      regs.skip_header    = 1'b0;
      in_field   = 1'b0;
      quoted     = 1'b0;
      escaping   = 1'b0;
      await_term = 1'b0;
      cur_field  = '0;
      row_count  = '0;
      err        = STATUS_OK;
      mismatches = 0;
      checked    = 0;
    endfunction

    function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        CFG_QUOTE:      regs.quote_char     = v[7:0];
        CFG_SEPARATOR:  regs.separator_char = v[7:0];
        CFG_RECORD:     regs.record_char    = v[7:0];
        CFG_NUM_FIELDS: regs.num_fields     = v[6:0];
        CFG_LOAD_MASK:  regs.load_mask      = v;
        CFG_SKIP_HDR:   regs.skip_header    = v[0];
        default: ;
      endcase
    endfunction

    // zero fields act as one, anything past the maximum as the maximum
    function bit last_field();
      int total;
      if (regs.num_fields == '0) total = 1;
      else if (regs.num_fields > 7'(MAX_FIELDS)) total = MAX_FIELDS;
      else total = int'(regs.num_fields);
      return (int'(cur_field) + 1) >= total;
    endfunction

    function logic [7:0] terminator();
      return last_field() ? regs.record_char : regs.separator_char;
    endfunction

    function bit row_clean();
      return !in_field && !await_term && cur_field == '0;
    endfunction

    // Advance the parser by one item and queue the result it must produce.
    function void classify(logic kind, logic [7:0] b);
      result_t    r;
      logic [7:0] term;
      bit         last;
      bit         wanted;
      bit         ended;
      bit         escaped;
      r       = '0;
      last    = last_field();
      term    = terminator();
      wanted  = regs.load_mask[cur_field] && !(regs.skip_header && row_count == '0);
      ended   = 1'b0;
      escaped = 1'b0;
      r.field_number = cur_field;
      if (kind) begin
        if (err == STATUS_OK && (in_field || await_term || cur_field != '0))
          err = STATUS_INCOMPLETE;
        r.rows_seen  = (regs.skip_header && row_count != '0) ? row_count - 32'd1 : row_count;
        r.end_report = 1'b1;
      end else if (err == STATUS_OK) begin
        if (await_term) begin
          await_term = 1'b0;
          if (b == term) ended = 1'b1;
          else err = STATUS_BAD_TERM;
        end else begin
          if (escaping && b != BACKSLASH_BYTE && b != DQUOTE_BYTE) begin
            r.blank_previous = 1'b1;
            escaping = 1'b0;
          end
          if (b == BACKSLASH_BYTE) escaping = !escaping;
          if (b == DQUOTE_BYTE && escaping) begin
            escaped  = 1'b1;
            escaping = 1'b0;
          end
          if (!in_field) begin
            if (b == regs.quote_char) begin
              in_field = 1'b1;
              quoted   = 1'b1;
            end else if (b == term) begin
              ended = 1'b1;
            end else begin
              in_field = 1'b1;
              quoted   = 1'b0;
              r.content_valid = 1'b1;
            end
          end else if (quoted) begin
            if (b == regs.quote_char && !escaped) begin
              in_field   = 1'b0;
              quoted     = 1'b0;
              await_term = 1'b1;
            end else begin
              r.content_valid = 1'b1;
            end
          end else if (b == term) begin
            in_field = 1'b0;
            ended    = 1'b1;
          end else begin
            r.content_valid = 1'b1;
          end
        end
        if (ended) begin
          r.field_done = 1'b1;
          if (last) begin
            r.row_done = 1'b1;
            if (row_count != '1) row_count++;
            cur_field = '0;
          end else begin
            cur_field = cur_field + FIELD_W'(1);
          end
        end
        // a bad terminator blanks everything but index, status and count
        if (err == STATUS_OK) begin
          r.content_byte = b;
          r.field_wanted = wanted;
        end
      end
      if (!kind) r.rows_seen = row_count;
      r.status = err;
      tokens_due.push_back(r);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      mismatches++;
      if (mismatches <= 40)
        $display("%0t: result %0d %s: got 0x%0h, want 0x%0h", $time, checked, what, got, want);
    endtask

    task field_check(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) report(name, got, want);
    endtask

    task check_token(result_t got);
      result_t want;
      if (tokens_due.size() == 0) begin
        report("arrived with nothing outstanding", 32'(got.content_byte), 32'd0);
        return;
      end
      want = tokens_due.pop_front();
      field_check("content_valid",  32'(got.content_valid),  32'(want.content_valid));
      field_check("content_byte",   32'(got.content_byte),   32'(want.content_byte));
      field_check("field_number",   32'(got.field_number),   32'(want.field_number));
      field_check("field_done",     32'(got.field_done),     32'(want.field_done));
      field_check("field_wanted",   32'(got.field_wanted),   32'(want.field_wanted));
      field_check("row_done",       32'(got.row_done),       32'(want.row_done));
      field_check("blank_previous", 32'(got.blank_previous), 32'(want.blank_previous));
      field_check("status",         32'(got.status),         32'(want.status));
      field_check("rows_seen",      got.rows_seen,           want.rows_seen);
      field_check("end_report",     32'(got.end_report),     32'(want.end_report));
      checked++;
    endtask

    task flush_check();
      if (tokens_due.size() != 0) report("results never delivered", tokens_due.size(), 0);
    endtask
  endclass

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   rx_ready = 1'b0;

  csvfs_text_if  text_ch ();
  csvfs_token_if token_ch ();

  // The result side's ready comes from the stall pattern below.
  assign token_ch.ready = rx_ready;

  csv_field_splitter_top dut (
    .clk       (clk),
    .rst       (rst),
    .text      (text_ch),
    .tokens    (token_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  token_scoreboard board;
  int burst_left    = 0;
  int items_sent    = 0;
  int ends_sent     = 0;
  int settings_used = 0;
  int rx_cycle      = 0;
  int rx_mode       = 0;

  always #5 clk = ~clk;

  // Send one item. Between bursts drop valid for a random gap; inside a burst
  // keep valid high and just swap the payload. Return on the accepting edge.
  task automatic send_item(input logic kind, input logic [7:0] b);
    if (burst_left == 0) begin
      text_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 150 : $urandom_range(1, 30);
    end
    burst_left--;
    text_ch.valid   <= 1'b1;
    text_ch.kind    <= kind;
    text_ch.in_byte <= b;
    @(posedge clk);
    while (!text_ch.ready) @(posedge clk);
    board.classify(kind, b);
    items_sent++;
    if (kind) ends_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_item(1'b0, s[i]);
  endtask

  // Hold the input idle until every outstanding result is back, plus the
  // two pipeline stages and some margin.
  task automatic settle();
    text_ch.valid <= 1'b0;
    while (board.tokens_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    board.set_reg(idx, v);
    @(posedge clk);
  endtask

  // Drain the block, then rewrite all six registers back to back.
  task automatic configure(logic [7:0] q, logic [7:0] s, logic [7:0] r, logic [6:0] nf,
                           logic [63:0] mask, logic skip);
    settle();
    write_reg(CFG_QUOTE, 64'(q));
    write_reg(CFG_SEPARATOR, 64'(s));
    write_reg(CFG_RECORD, 64'(r));
    write_reg(CFG_NUM_FIELDS, 64'(nf));
    write_reg(CFG_LOAD_MASK, mask);
    write_reg(CFG_SKIP_HDR, 64'(skip));
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Byte mix biased toward the characters that steer the parser.
  function automatic logic [7:0] pick_byte();
    int unsigned r = $urandom_range(0, 99);
    if (r < 14) return board.regs.quote_char;
    if (r < 34) return board.regs.separator_char;
    if (r < 48) return board.regs.record_char;
    if (r < 56) return BACKSLASH_BYTE;
    if (r < 61) return DQUOTE_BYTE;
    return 8'($urandom);
  endfunction

  // Well-formed text with random content: always close a quoted field with
  // the right terminator, and end input only on a row boundary, so the
  // sticky status stays clean. Dense mode ends fields fast for wide rows.
  task automatic send_clean(int n, bit dense);
    for (int i = 0; i < n; i++) begin
      if (board.await_term) send_item(1'b0, board.terminator());
      else if (board.row_clean() && $urandom_range(0, 24) == 0) send_item(1'b1, 8'($urandom));
      else if (dense && $urandom_range(0, 1) == 1) send_item(1'b0, board.terminator());
      else send_item(1'b0, pick_byte());
    end
  endtask

  // Result side: check every accepted result, then pick the next ready.
  // The stall style is redrawn at random from: none, light random, one in
  // four, or mostly stalled.
  always @(posedge clk) begin
    result_t got;
    if (!rst && token_ch.valid && rx_ready) begin
      got.content_valid  = token_ch.content_valid;
      got.content_byte   = token_ch.content_byte;
      got.field_number   = token_ch.field_number;
      got.field_done     = token_ch.field_done;
      got.field_wanted   = token_ch.field_wanted;
      got.row_done       = token_ch.row_done;
      got.blank_previous = token_ch.blank_previous;
      got.status         = status_t'(token_ch.status);
      got.rows_seen      = token_ch.rows_seen;
      got.end_report     = token_ch.end_report;
      board.check_token(got);
    end
    rx_cycle++;
    if (rx_cycle % 64 == 0) rx_mode = $urandom_range(0, 3);
    case (rx_mode)
      0: rx_ready <= 1'b1;
      1: rx_ready <= ($urandom_range(0, 9) < 7);
      2: rx_ready <= (rx_cycle % 4 == 0);
      default: rx_ready <= ($urandom_range(0, 9) == 0);
    endcase
  end

  initial begin
    logic [7:0] filler;
    int         w;
    board = new();
    rst             <= 1'b1;
    cfg_we          <= 1'b0;
    cfg_index       <= CFG_QUOTE;
    cfg_data        <= '0;
    text_ch.valid   <= 1'b0;
    text_ch.kind    <= 1'b0;
    text_ch.in_byte <= 8'h00;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: three fields, fields 0 and 2 wanted, first row is a header.
    configure(8'h22, 8'h2C, 8'h0A, 7'd3, 64'h5, 1'b1);
    // header row with a quoted middle field, then an end marker on a clean
    // row boundary (header dropped from the count)
    send_text("h,\"q\",x\n");
    send_item(1'b1, 8'hFF);
    // escaped quote inside quotes, stray escape, doubled backslash
    send_text("\"a\\\"b\",\\z,\\\\\n");
    // empty fields, then the byte extremes as content
    send_text(",,\n");
    send_item(1'b0, 8'h2C);
    send_item(1'b0, 8'h00);
    send_item(1'b0, 8'h2C);
    send_item(1'b0, 8'hFF);
    send_item(1'b0, 8'h0A);

    // Random phases over a spread of register settings.
    configure(8'h22, 8'h2C, 8'h0A, 7'd1, '1, 1'b0);
    send_clean(70, 1'b0);
    // widest rows, quote equal to record, zero and all-ones delimiters
    configure(8'h00, 8'hFF, 8'h00, 7'd64, {$urandom, $urandom}, 1'b0);
    send_clean(150, 1'b1);
    // quote equal to separator, zero field count, nothing wanted
    configure(8'h2C, 8'h2C, 8'h3B, 7'd0, 64'h0, 1'b1);
    send_clean(70, 1'b0);
    // field count above the maximum
    configure(8'hFF, 8'h09, 8'hFF, 7'd127, '1, 1'b0);
    send_clean(150, 1'b1);
    // shrink the row mid-stream so the field index can sit past the end
    configure(8'($urandom), 8'($urandom), 8'($urandom), 7'($urandom_range(1, 8)),
              {$urandom, $urandom}, 1'($urandom));
    send_clean(60, 1'b0);
    configure(8'($urandom), 8'h00, 8'($urandom), 7'd2, {$urandom, $urandom}, 1'($urandom));
    send_clean(60, 1'b0);

    // Last phase: the status is sticky, so break the stream only once, at
    // the very end, then keep pushing noise and end markers at the dead parser.
    configure(8'h22, 8'h2C, 8'h0A, 7'($urandom_range(1, 4)), {$urandom, $urandom}, 1'b0);
    send_clean(30, 1'b0);
    while (board.await_term || board.in_field)
      send_item(1'b0, board.await_term ? board.terminator() : pick_byte());
    do filler = 8'($urandom);
    while (filler == 8'h22 || filler == 8'h2C || filler == 8'h0A || filler == BACKSLASH_BYTE);
    if ($urandom_range(0, 1) == 1) begin
      // quoted field closed by a wrong byte
      send_item(1'b0, 8'h22);
      send_item(1'b0, filler);
      send_item(1'b0, 8'h22);
      send_item(1'b0, board.terminator() ^ 8'h01);
    end else begin
      // input ends in the middle of a row
      send_item(1'b0, filler);
      send_item(1'b1, 8'($urandom));
    end
    for (int i = 0; i < 50; i++) send_item($urandom_range(0, 9) == 0, 8'($urandom));
    send_item(1'b1, 8'h00);
    send_item(1'b1, 8'hFF);

    // Drain, allow for the pipeline, then judge.
    text_ch.valid <= 1'b0;
    for (w = 0; w < 5000 && board.tokens_due.size() != 0; w++) @(posedge clk);
    repeat (10) @(posedge clk);
    board.flush_check();
    $display("Summary: %0d items (%0d end markers) over %0d register settings, %0d results checked",
             items_sent, ends_sent, settings_used, board.checked);
    $display("Summary: %0d rows counted, final status %s, %0d mismatches",
             board.row_count, board.err.name(), board.mismatches);
    if (board.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #3_000_000;
    $display("Timeout with %0d results outstanding", board.tokens_due.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
